>>> rtl/pbd_pkg.sv
// Package for the PEM base64 body decoder.
// Holds the phase, token and queue status types, character constants and lookup functions.
// No dependencies.
`timescale 1ns / 1ps

package pbd_pkg;

    localparam int COUNT_BITS_DEF  = 24;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int FIELD_W         = 24;
    localparam int TDATA_W         = 64;
    localparam int HDR_LEN         = 10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [3:0] HDR_LAST    = 4'd9;
    localparam logic [3:0] HDR_DASHES  = 4'd5;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DECODE = 2'd2,
        PH_STOP   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_b64;
        logic [5:0] sextet;
    } t_tok;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    function automatic logic [7:0] hdr_char(input logic [3:0] k);
        logic [7:0] ch;
        case (k)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ch = CH_DASH;
            4'd5:    ch = 8'h42;
            4'd6:    ch = 8'h45;
            4'd7:    ch = 8'h47;
            4'd8:    ch = 8'h49;
            4'd9:    ch = 8'h4E;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic t_tok classify(input logic [7:0] c);
        t_tok t;
        t.text_byte = c;
        t.is_b64    = 1'b1;
        t.sextet    = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            t.sextet = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t.sextet = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t.sextet = 6'(c - 8'h30 + 8'd52);
        end else if (c == CH_PLUS) begin
            t.sextet = 6'd62;
        end else if (c == CH_SLASH) begin
            t.sextet = 6'd63;
        end else begin
            t.is_b64 = 1'b0;
        end
        return t;
    endfunction

endpackage

>>> rtl/pem_base64_body_decoder_unit.sv
// Top level of the PEM base64 body decoder: front end, token queue, back end.
// Depends on pbd_pkg, pbd_front, pbd_queue and pbd_back.
//
//  channel   direction  handshake                         payload
//  s_axis    in         i_s_axis_tvalid / o_s_axis_tready  tdata[7:0] text_byte
//  m_axis    out        o_m_axis_tvalid / i_m_axis_tready  tdata[56:0], tuser[0] kind
//
// One byte per cycle sustained while the output does not stall; each byte is
// queued, and its result, if any, is registered at the edge that takes it from
// the queue. The back end's state update sets this rate while the output is free.
// Reset is synchronous, active low; it empties the queue and restarts search.
// A stalled output holds its result; the queue absorbs input while it stalls.
`timescale 1ns / 1ps

module pem_base64_body_decoder_unit
    import pbd_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // text_byte[7:0]
    input  logic [7:0]         i_s_axis_tdata,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // data_byte[7:0], found[8], byte_count[32:9], header_offset[56:33], zeros
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    // kind[0]
    output logic [0:0]         o_m_axis_tuser
);

    t_q_stat q_stat;
    t_tok    push_tok;
    t_tok    head_tok;
    logic    push;
    logic    pop;

    pbd_front u_front (
        .i_valid  (i_s_axis_tvalid),
        .i_byte   (i_s_axis_tdata),
        .i_q_stat (q_stat),
        .o_ready  (o_s_axis_tready),
        .o_push   (push),
        .o_tok    (push_tok)
    );

    pbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .i_pop   (pop),
        .o_tok   (head_tok),
        .o_stat  (q_stat)
    );

    pbd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_tok    (head_tok),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser)
    );

    a_sum_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata[7:0] == 8'd0))
        else $error("summary result carries a data byte");

    a_data_no_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[56:8] == '0))
        else $error("data result carries summary fields");

    a_rose_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(pop))
        else $error("result appeared without a token leaving the queue");

    a_pop_needs_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_stat.valid && !push) |=> !pop)
        else $error("back end took a token from an empty queue");

endmodule

>>> rtl/pbd_front.sv
// Front end of the PEM base64 body decoder: accepts bytes and classifies them.
// Depends on pbd_pkg; feeds pbd_queue.
`timescale 1ns / 1ps

module pbd_front
    import pbd_pkg::*;
(
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  t_q_stat    i_q_stat,
    output logic       o_ready,
    output logic       o_push,
    output t_tok       o_tok
);

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;
    assign o_tok   = classify(i_byte);

endmodule

>>> rtl/pbd_queue.sv
// Short token queue between the front end and the back end.
// Depends on pbd_pkg; depth must be a power of two of at least two.
`timescale 1ns / 1ps

module pbd_queue
    import pbd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_tok    i_tok,
    input  logic    i_pop,
    output t_tok    o_tok,
    output t_q_stat o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_tok          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_tok        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.valid = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/pbd_back.sv
// Back end of the PEM base64 body decoder: header matcher, phase machine,
// base64 accumulator, counters and the output register. Depends on pbd_pkg.
`timescale 1ns / 1ps

module pbd_back
    import pbd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_stat            i_q_stat,
    input  t_tok               i_tok,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [TDATA_W-1:0] o_tdata,
    output logic [0:0]         o_tuser
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    t_phase                r_phase, n_phase;
    logic [3:0]            r_match, n_match;
    logic [COUNT_BITS-1:0] r_position, n_position;
    logic [COUNT_BITS-1:0] r_saved, n_saved;
    logic [5:0]            r_pbits, n_pbits;
    logic [2:0]            r_pcnt, n_pcnt;
    logic [COUNT_BITS-1:0] r_dcount, n_dcount;

    logic                  r_out_valid, n_out_valid;
    logic [TDATA_W-1:0]    r_out_tdata, n_out_tdata;
    logic [0:0]            r_out_tuser, n_out_tuser;

    logic [7:0]            c;
    logic [3:0]            k;
    logic [3:0]            nb;
    logic [2:0]            nbn;
    logic [11:0]           acc;
    logic [11:0]           acc_sh;
    logic [6:0]            pmask;
    logic [COUNT_BITS+FIELD_W-1:0] ext_cnt;
    logic [COUNT_BITS+FIELD_W-1:0] ext_off;
    logic                  sum_found;
    logic [FIELD_W-1:0]    sum_cnt;
    logic [FIELD_W-1:0]    sum_off;

    assign o_pop   = i_q_stat.valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_tdata = r_out_tdata;
    assign o_tuser = r_out_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_match     <= '0;
            r_position  <= '0;
            r_saved     <= '0;
            r_pbits     <= '0;
            r_pcnt      <= '0;
            r_dcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_match     <= n_match;
            r_position  <= n_position;
            r_saved     <= n_saved;
            r_pbits     <= n_pbits;
            r_pcnt      <= n_pcnt;
            r_dcount    <= n_dcount;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_tdata <= n_out_tdata;
        r_out_tuser <= n_out_tuser;
    end

    always_comb begin
        c          = i_tok.text_byte;
        k          = (r_match > HDR_LAST) ? 4'd0 : r_match;
        nb         = ((r_pcnt > 3'd6) ? 4'd6 : {1'b0, r_pcnt}) + 4'd6;
        nbn        = (nb >= 4'd8) ? 3'(nb - 4'd8) : nb[2:0];
        acc        = {r_pbits, i_tok.sextet};
        acc_sh     = acc >> nbn;
        pmask      = (7'd1 << nbn) - 7'd1;
        ext_cnt    = {{FIELD_W{1'b0}}, r_dcount};
        ext_off    = {{FIELD_W{1'b0}}, r_saved};
        sum_found  = (r_phase == PH_DECODE) || (r_phase == PH_STOP);
        sum_cnt    = sum_found ? ext_cnt[FIELD_W-1:0] : '0;
        sum_off    = (r_phase != PH_SEARCH) ? ext_off[FIELD_W-1:0] : '0;

        n_phase     = r_phase;
        n_match     = r_match;
        n_position  = r_position;
        n_saved     = r_saved;
        n_pbits     = r_pbits;
        n_pcnt      = r_pcnt;
        n_dcount    = r_dcount;
        n_out_valid = r_out_valid && !i_ready;
        n_out_tdata = r_out_tdata;
        n_out_tuser = r_out_tuser;

        if (o_pop) begin
            if (r_position != CNT_MAX) begin
                n_position = r_position + COUNT_BITS'(1);
            end
            if (c == CH_NUL) begin
                n_out_valid = 1'b1;
                n_out_tuser = 1'b1;
                n_out_tdata = {7'd0, sum_off, sum_cnt, sum_found, 8'd0};
                n_phase     = PH_SEARCH;
                n_match     = '0;
                n_position  = '0;
                n_saved     = '0;
                n_pbits     = '0;
                n_pcnt      = '0;
                n_dcount    = '0;
            end else begin
                case (r_phase)
                    PH_SEARCH: begin
                        if (c == hdr_char(k)) begin
                            n_match = k + 4'd1;
                        end else if (k == HDR_DASHES && c == CH_DASH) begin
                            n_match = HDR_DASHES;
                        end else if (c == CH_DASH) begin
                            n_match = 4'd1;
                        end else begin
                            n_match = 4'd0;
                        end
                        if (n_match >= 4'(HDR_LEN)) begin
                            n_saved = r_position - COUNT_BITS'(HDR_LEN - 1);
                            n_match = 4'd0;
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        if (c == CH_NL) begin
                            n_phase = PH_DECODE;
                        end
                    end
                    PH_DECODE: begin
                        if (c == CH_DASH || c == CH_EQ) begin
                            n_phase = PH_STOP;
                        end else if (i_tok.is_b64) begin
                            if (nb >= 4'd8) begin
                                n_out_valid = 1'b1;
                                n_out_tuser = 1'b0;
                                n_out_tdata = {{(TDATA_W-8){1'b0}}, acc_sh[7:0]};
                                if (r_dcount != CNT_MAX) begin
                                    n_dcount = r_dcount + COUNT_BITS'(1);
                                end
                            end
                            n_pbits = acc[5:0] & pmask[5:0];
                            n_pcnt  = nbn;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
